/* rtl/jszc_pkg.sv */
// Shared types and constants for the joystick smoothing and zone classifier.
`timescale 1ns / 1ps
`default_nettype none

package jszc_pkg;

    localparam int DEF_SAMPLE_BITS      = 10;
    localparam int DEF_WEIGHT_FRAC_BITS = 8;

    localparam int NUM_AXES   = 4;
    localparam int NUM_LIMITS = 6;
    localparam int ZONE_W     = 3;

    // Threshold reset values are given for 10-bit samples and scaled to the sample width.
    localparam int LIMIT_REF_BITS = 10;
    localparam int LIMIT_RESET [NUM_LIMITS] = '{128, 320, 480, 544, 704, 896};

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMOOTHING_WEIGHT     = 3'd0,
        REG_FAST_BACK_LIMIT      = 3'd1,
        REG_MEDIUM_BACK_LIMIT    = 3'd2,
        REG_DEAD_ZONE_LOW        = 3'd3,
        REG_DEAD_ZONE_HIGH       = 3'd4,
        REG_MEDIUM_FORWARD_LIMIT = 3'd5,
        REG_FAST_FORWARD_LIMIT   = 3'd6
    } cfg_reg_t;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_BACK_FAST   = 3'd0,
        ZONE_BACK_MEDIUM = 3'd1,
        ZONE_BACK_SLOW   = 3'd2,
        ZONE_NEUTRAL     = 3'd3,
        ZONE_FWD_SLOW    = 3'd4,
        ZONE_FWD_MEDIUM  = 3'd5,
        ZONE_FWD_FAST    = 3'd6
    } zone_t;

endpackage

`default_nettype wire

/* rtl/jszc_axis.sv */
// One axis: weighted update of the smoothed level and its zone decision.
`timescale 1ns / 1ps
`default_nettype none

module jszc_axis
    import jszc_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
    input  wire logic [WEIGHT_FRAC_BITS-1:0]              weight,
    input  wire logic [SAMPLE_BITS-1:0]                   old_level,
    input  wire logic [SAMPLE_BITS-1:0]                   sample,
    input  wire logic [NUM_LIMITS-1:0][SAMPLE_BITS-1:0]   limits,
    output logic      [SAMPLE_BITS-1:0]                   new_level,
    output zone_t                                         zone
);

    localparam int ACC_W = SAMPLE_BITS + WEIGHT_FRAC_BITS + 1;

    logic [WEIGHT_FRAC_BITS:0] inv_weight;
    logic [ACC_W-1:0]          acc;

    // The complement weight can reach one whole unit, so it needs one more bit.
    assign inv_weight = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}} - {1'b0, weight};

    assign acc = ACC_W'(ACC_W'(weight) * ACC_W'(old_level))
               + ACC_W'(ACC_W'(inv_weight) * ACC_W'(sample));

    assign new_level = acc[WEIGHT_FRAC_BITS +: SAMPLE_BITS];

    // The first threshold in register order that the level is below wins.
    always_comb begin
        zone = ZONE_FWD_FAST;
        for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
            if (new_level < limits[i]) begin
                zone = zone_t'(ZONE_W'(i));
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/joystick_smooth_zone_classifier.sv */
// Top level: four-axis joystick smoother and zone classifier with stream ports.
//
//  Channel  Ports                           Payload (lowest bits first)
//  -------  ------------------------------  ------------------------------------------
//  input    s_tvalid s_tready s_tdata       left_x, left_y, right_x, right_y sample
//  result   m_tvalid m_tready m_tdata       four zones, then four smoothed levels
//  config   cfg_valid cfg_ready cfg_index   register index, cfg_data write value
//
//  One item per clock while s_tready is high: the level update and zone decision are
//  combinational, one multiply-add and six compares per axis ahead of the result register.
//  Unless the result is stalled, it appears on m_tdata the cycle after its input transfer.
//  A skid register lets one more item in while a result is stalled; s_tready
//  drops only while both the result and skid registers are full.
//  Reset sets all smoothed levels to mid-scale and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module joystick_smooth_zone_classifier
    import jszc_pkg::*;
#(
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
    localparam int IN_W   = ((NUM_AXES * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((NUM_AXES * (ZONE_W + SAMPLE_BITS) + 7) / 8) * 8,
    localparam int CFG_W  = (SAMPLE_BITS > WEIGHT_FRAC_BITS) ? SAMPLE_BITS
                                                             : WEIGHT_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // left_x_sample, left_y_sample, right_x_sample, right_y_sample, zero fill
    input  wire logic [IN_W-1:0]        s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // left_x_zone, left_y_zone, right_x_zone, right_y_zone,
    // left_x_level, left_y_level, right_x_level, right_y_level, zero fill
    output logic      [OUT_W-1:0]       m_tdata,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int PAY_W = NUM_AXES * (ZONE_W + SAMPLE_BITS);
    localparam logic [WEIGHT_FRAC_BITS-1:0] WEIGHT_RESET =
        WEIGHT_FRAC_BITS'(3 << (WEIGHT_FRAC_BITS - 2));
    localparam logic [SAMPLE_BITS-1:0] MID_SCALE = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

    logic [WEIGHT_FRAC_BITS-1:0]            weight_reg;
    logic [NUM_LIMITS-1:0][SAMPLE_BITS-1:0] limits_reg;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   levels_reg;
    logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]   levels_next;
    logic [NUM_AXES-1:0][ZONE_W-1:0]        zones_next;

    logic [PAY_W-1:0] out_data_reg;
    logic [PAY_W-1:0] skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [PAY_W-1:0] result_next;
    logic             in_xfer;
    logic             out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            for (int i = 0; i < NUM_LIMITS; i++) begin
                limits_reg[i] <= SAMPLE_BITS'((LIMIT_RESET[i] << SAMPLE_BITS) >> LIMIT_REF_BITS);
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SMOOTHING_WEIGHT:     weight_reg    <= cfg_data[WEIGHT_FRAC_BITS-1:0];
                REG_FAST_BACK_LIMIT:      limits_reg[0] <= cfg_data[SAMPLE_BITS-1:0];
                REG_MEDIUM_BACK_LIMIT:    limits_reg[1] <= cfg_data[SAMPLE_BITS-1:0];
                REG_DEAD_ZONE_LOW:        limits_reg[2] <= cfg_data[SAMPLE_BITS-1:0];
                REG_DEAD_ZONE_HIGH:       limits_reg[3] <= cfg_data[SAMPLE_BITS-1:0];
                REG_MEDIUM_FORWARD_LIMIT: limits_reg[4] <= cfg_data[SAMPLE_BITS-1:0];
                REG_FAST_FORWARD_LIMIT:   limits_reg[5] <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        zone_t axis_zone;

        jszc_axis #(
            .SAMPLE_BITS      (SAMPLE_BITS),
            .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
        ) u_axis (
            .weight    (weight_reg),
            .old_level (levels_reg[a]),
            .sample    (s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]),
            .limits    (limits_reg),
            .new_level (levels_next[a]),
            .zone      (axis_zone)
        );

        assign zones_next[a] = axis_zone;
    end

    assign result_next = {levels_next, zones_next};

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                levels_reg[a] <= MID_SCALE;
            end
        end else if (in_xfer) begin
            levels_reg <= levels_next;
        end
    end

    // The skid register fills only when a new item arrives while the result stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_xfer;
            skid_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_xfer) begin
                out_data_reg <= result_next;
            end
        end else if (in_xfer) begin
            skid_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

`default_nettype wire
